// ===== hw/rtl/tnsk_pkg.sv =====
`timescale 1ns / 1ps

package tnsk_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 32;
  localparam int ROW_W    = 31;
  localparam int RANK_W   = 4;
  localparam int KEEP_W   = 5;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int EFF_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SORT_ORDER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = CFG_IDX_W'(1);

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DRAIN
  } cell_op_e;

  typedef struct packed {
    logic                       valid;
    logic signed [KEY_BITS-1:0] key;
    logic [ROW_W-1:0]           row;
  } slot_t;

  typedef struct packed {
    cell_op_e                   op;
    logic                       desc;
    logic signed [KEY_BITS-1:0] key;
    logic [ROW_W-1:0]           row;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [ROW_W-1:0]           row_id;
    logic                       last;
  } in_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_id_res;
    logic [RANK_W-1:0] rank;
    logic              last_result;
  } out_beat_t;

endpackage

// ===== hw/rtl/tnsk_cell.sv =====
`timescale 1ns / 1ps

module tnsk_cell
  import tnsk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       in_keep_i,
  input  logic       found_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  output logic       found_o,
  output slot_t      slot_o
);

  logic                       valid_q, valid_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic                       live;
  logic                       beat;
  logic                       take;

  assign live    = valid_q & in_keep_i;
  assign beat    = ctrl_i.desc ? ($signed(ctrl_i.key) > $signed(key_q))
                               : ($signed(ctrl_i.key) < $signed(key_q));
  assign take    = in_keep_i & (~live | beat);
  assign found_o = found_i | take;
  assign slot_o  = '{valid: valid_q, key: key_q, row: row_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    row_d   = row_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (found_i) begin
          valid_d = left_i.valid & in_keep_i;
          key_d   = left_i.key;
          row_d   = left_i.row;
        end else if (take) begin
          valid_d = 1'b1;
          key_d   = ctrl_i.key;
          row_d   = ctrl_i.row;
        end else begin
          valid_d = live;
        end
      end
      OP_DRAIN: begin
        valid_d = right_i.valid;
        key_d   = right_i.key;
        row_d   = right_i.row;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    row_q <= row_d;
  end

endmodule

// ===== hw/rtl/top_n_select_by_key.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Beat
// in       input      in_valid_i / in_ready_o    in_beat_t: key, row_id, last
// out      output     out_valid_o / out_ready_i  out_beat_t: row_id_res, rank, last_result
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// An input beat is inserted into the slot chain; one beat is taken per cycle while the chain is not draining.
// A beat marked last is followed by one result beat per kept entry, drained from the head cell;
// input is refused while the chain drains.
// Reset empties the chain and sets ascending order with sixteen kept entries.
// A stalled result holds the chain; nothing is lost on either side.

module top_n_select_by_key
  import tnsk_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              desc_q, desc_d;
  logic [KEEP_W-1:0] keep_q, keep_d;
  logic              drain_q, drain_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [EFF_W-1:0]  keep_eff;
  logic              in_acc;
  logic              out_acc;
  cell_ctrl_t        ctrl;
  slot_t             slots [SLOTS];
  slot_t             left  [SLOTS];
  slot_t             right [SLOTS];
  logic [SLOTS:0]    found;
  logic [SLOTS-1:0]  in_keep;
  logic [SLOTS-1:0]  valid_vec;

  assign in_ready_o  = ~drain_q;
  assign out_valid_o = drain_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  always_comb begin
    if (keep_q == '0) begin
      keep_eff = EFF_W'(1);
    end else if (EFF_W'(keep_q) > EFF_W'(SLOTS)) begin
      keep_eff = EFF_W'(SLOTS);
    end else begin
      keep_eff = EFF_W'(keep_q);
    end
  end

  always_comb begin
    ctrl.op   = OP_HOLD;
    ctrl.desc = desc_q;
    ctrl.key  = in_data_i.key;
    ctrl.row  = in_data_i.row_id;
    if (in_acc) begin
      ctrl.op = OP_INSERT;
    end else if (out_acc) begin
      ctrl.op = OP_DRAIN;
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign in_keep[i]   = EFF_W'(i) < keep_eff;
    assign valid_vec[i] = slots[i].valid;
    if (i == 0) begin : g_head
      assign left[i] = '0;
    end else begin : g_mid
      assign left[i] = slots[i-1];
    end
    if (i == SLOTS - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_body
      assign right[i] = slots[i+1];
    end

    tnsk_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .in_keep_i (in_keep[i]),
      .found_i   (found[i]),
      .left_i    (left[i]),
      .right_i   (right[i]),
      .found_o   (found[i+1]),
      .slot_o    (slots[i])
    );
  end

  assign out_data_o.row_id_res  = slots[0].row;
  assign out_data_o.rank        = rank_q;
  assign out_data_o.last_result = ~right[0].valid;

  always_comb begin
    drain_d = drain_q;
    rank_d  = rank_q;
    if (in_acc && in_data_i.last) begin
      drain_d = 1'b1;
      rank_d  = '0;
    end else if (out_acc) begin
      rank_d = rank_q + RANK_W'(1);
      if (out_data_o.last_result) begin
        drain_d = 1'b0;
      end
    end
  end

  always_comb begin
    desc_d = desc_q;
    keep_d = keep_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_SORT_ORDER) begin
        desc_d = cfg_data_i[0];
      end else if (cfg_idx_i == REG_KEEP_COUNT) begin
        keep_d = cfg_data_i[KEEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q  <= 1'b0;
      keep_q  <= KEEP_RESET;
      drain_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      desc_q  <= desc_d;
      keep_q  <= keep_d;
      drain_q <= drain_d;
      rank_q  <= rank_d;
    end
  end

  a_drain_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> slots[0].valid)
    else $error("head cell empty while results drain");

  a_slots_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + SLOTS'(1)) & valid_vec) == '0)
    else $error("occupied cells do not form a prefix of the chain");

  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last) |=> (out_valid_o && rank_q == '0))
    else $error("last input beat did not start the result drain");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.last_result) |=> (in_ready_o && valid_vec == '0))
    else $error("chain not empty after the final result beat");

endmodule

// ===== tb/top_n_select_by_key_test.sv =====
`timescale 1ns / 1ps

module top_n_select_by_key_test;
  import tnsk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ROWS   = 160;
  localparam int HOLD_CYCLES   = 250;

  class rank_list_sb;
    out_beat_t          pending_ranks[$];
    logic [KEY_BITS-1:0] held_keys[SLOTS];
    logic [ROW_W-1:0]    held_rows[SLOTS];
    int                  held_count;
    logic                descending;
    logic [KEEP_W-1:0]   keep_reg;
    int                  mismatches;

    function new();
      held_count = 0;
      descending = 1'b0;
      keep_reg   = KEEP_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SORT_ORDER: descending = data[0];
        REG_KEEP_COUNT: keep_reg = data[KEEP_W-1:0];
        default: ;
      endcase
    endfunction

    function bit beats(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
      return descending ? (a > b) : (a < b);
    endfunction

    function void note_row(in_beat_t beat);
      int keep;
      int pos;
      int stop;
      logic [KEY_BITS-1:0] okey;
      out_beat_t r;
      keep = (keep_reg == 0) ? 1 : ((keep_reg > SLOTS) ? SLOTS : int'(keep_reg));
      // A lowered keep count trims the worst entries before the insertion.
      if (held_count > keep) held_count = keep;
      okey = {~beat.key[KEY_BITS-1], beat.key[KEY_BITS-2:0]};
      pos = held_count;
      for (int i = 0; i < held_count; i++) begin
        if (pos == held_count && beats(okey, held_keys[i])) pos = i;
      end
      if (pos < keep) begin
        stop = (held_count < keep) ? held_count : keep - 1;
        for (int i = stop; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_rows[i] = held_rows[i-1];
        end
        held_keys[pos] = okey;
        held_rows[pos] = beat.row_id;
        if (held_count < keep) held_count++;
      end
      if (beat.last) begin
        for (int i = 0; i < held_count; i++) begin
          r.row_id_res  = held_rows[i];
          r.rank        = RANK_W'(i);
          r.last_result = (i + 1 == held_count);
          pending_ranks = {pending_ranks, r};
        end
        held_count = 0;
      end
    endfunction

    function void check_rank(out_beat_t got);
      out_beat_t want;
      if (pending_ranks.size() == 0) begin
        $error("unexpected result beat: row_id_res %0d rank %0d last_result %0d",
               got.row_id_res, got.rank, got.last_result);
        mismatches++;
        return;
      end
      want = pending_ranks.pop_front();
      if (got.row_id_res !== want.row_id_res) begin
        $error("row_id_res: expected %0d, actual %0d", want.row_id_res, got.row_id_res);
        mismatches++;
      end
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, actual %0d", want.rank, got.rank);
        mismatches++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, actual %0d", want.last_result, got.last_result);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rank_list_sb sb;
  int          hold_len;
  bit          steady;
  int unsigned cycles;

  top_n_select_by_key uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles == CYCLE_LIMIT);
    $display("top_n_select_by_key_test: FAIL");
    $finish;
  end

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(KEY_BITS-1){1'b0}}};
      1: return {1'b0, {(KEY_BITS-1){1'b1}}};
      2, 3, 4: return KEY_BITS'(int'($urandom_range(0, 6)) - 3);
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  task automatic send_row(input logic [KEY_BITS-1:0] k, input logic [ROW_W-1:0] row,
                          input logic fin);
    in_beat_t beat;
    beat.key    = k;
    beat.row_id = row;
    beat.last   = fin;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_row(beat);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_ranks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_set(input int len, input bit cut_keep);
    for (int j = 0; j < len; j++) begin
      if (cut_keep && j == len / 2) begin
        settle();
        set_reg(REG_KEEP_COUNT, CFG_DATA_W'($urandom_range(1, 4)));
      end
      send_row(pick_key(), ROW_W'($urandom), j == len - 1);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_rank(out_data);
      if (hold_len != 0) begin
        stall_left = hold_len;
        hold_len   = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int random_rows;
    int set_len;
    logic [CFG_DATA_W-1:0] keep_pick;
    sb        = new();
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    hold_len  = 0;
    steady    = 1'b0;
    cycles    = 0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Ascending with the reset keep count: extreme keys and rows, a tie.
    send_row({1'b0, {(KEY_BITS-1){1'b1}}}, ROW_W'(0), 1'b0);
    send_row({1'b1, {(KEY_BITS-1){1'b0}}}, {ROW_W{1'b1}}, 1'b0);
    send_row(KEY_BITS'(0), ROW_W'(1), 1'b0);
    send_row(KEY_BITS'(-1), ROW_W'(2), 1'b0);
    send_row(KEY_BITS'(1), ROW_W'(3), 1'b0);
    send_row(KEY_BITS'(5), ROW_W'(4), 1'b0);
    send_row(KEY_BITS'(5), ROW_W'(5), 1'b0);
    send_row({1'b1, {(KEY_BITS-1){1'b0}}}, ROW_W'(6), 1'b1);
    send_row(KEY_BITS'(32'h1234_5678), ROW_W'(31'h5555_5555), 1'b1);
    settle();

    // Descending, three kept: entries drop out and losers are discarded.
    set_reg(REG_SORT_ORDER, CFG_DATA_W'(3));
    set_reg(REG_KEEP_COUNT, CFG_DATA_W'(3));
    send_row(KEY_BITS'(10), ROW_W'(10), 1'b0);
    send_row(KEY_BITS'(20), ROW_W'(11), 1'b0);
    send_row(KEY_BITS'(20), ROW_W'(12), 1'b0);
    send_row(KEY_BITS'(30), ROW_W'(13), 1'b0);
    send_row(KEY_BITS'(5), ROW_W'(14), 1'b0);
    send_row(KEY_BITS'(30), ROW_W'(15), 1'b1);
    settle();

    // A keep count of zero acts as one; the spare indexes change nothing.
    set_reg(REG_KEEP_COUNT, CFG_DATA_W'(0));
    set_reg(REG_SPARE_2, CFG_DATA_W'(31));
    set_reg(REG_SPARE_3, CFG_DATA_W'(0));
    send_row(KEY_BITS'(-7), ROW_W'(20), 1'b0);
    send_row(KEY_BITS'(9), ROW_W'(21), 1'b0);
    send_row(KEY_BITS'(9), ROW_W'(22), 1'b1);
    settle();

    // Oversized keep count saturates, then is lowered part-way through a set.
    set_reg(REG_SORT_ORDER, CFG_DATA_W'(0));
    set_reg(REG_KEEP_COUNT, CFG_DATA_W'(31));
    send_row(KEY_BITS'(40), ROW_W'(30), 1'b0);
    send_row(KEY_BITS'(10), ROW_W'(31), 1'b0);
    send_row(KEY_BITS'(30), ROW_W'(32), 1'b0);
    send_row(KEY_BITS'(20), ROW_W'(33), 1'b0);
    settle();
    set_reg(REG_KEEP_COUNT, CFG_DATA_W'(2));
    send_row(KEY_BITS'(25), ROW_W'(34), 1'b1);
    settle();

    // Long result stall while a further set is offered behind the first.
    set_reg(REG_KEEP_COUNT, CFG_DATA_W'(16));
    hold_len = HOLD_CYCLES;
    send_set(8, 1'b0);
    send_set(12, 1'b0);
    random_rows = 43;

    while (random_rows < RANDOM_ROWS) begin
      settle();
      if ($urandom_range(0, 1) == 1) set_reg(REG_SORT_ORDER, CFG_DATA_W'($urandom));
      case ($urandom_range(0, 5))
        0: keep_pick = CFG_DATA_W'(1);
        1: keep_pick = CFG_DATA_W'(16);
        2: keep_pick = CFG_DATA_W'(0);
        3: keep_pick = CFG_DATA_W'($urandom_range(17, 31));
        default: keep_pick = CFG_DATA_W'($urandom_range(2, 8));
      endcase
      set_reg(REG_KEEP_COUNT, keep_pick);
      if ($urandom_range(0, 7) == 0) begin
        set_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3,
                CFG_DATA_W'($urandom));
      end
      repeat ($urandom_range(1, 3)) begin
        set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(1, 12);
        send_set(set_len, set_len > 3 && $urandom_range(0, 9) == 0);
        random_rows += set_len;
        if (random_rows >= RANDOM_ROWS - 30) steady = 1'b1;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_ranks.size() == 0) begin
      $display("top_n_select_by_key_test: PASS");
    end else begin
      $display("top_n_select_by_key_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tnsk_pkg.sv
hw/rtl/tnsk_cell.sv
hw/rtl/top_n_select_by_key.sv
tb/top_n_select_by_key_test.sv
